### src/luhn_pkg.sv
// ----------------------------------------------------------------------------
// Luhn check digit unit package
// Shared constants, command codes and the word carried along the cell chain.
// ----------------------------------------------------------------------------
package luhn_pkg;

  // Decimal digits handled by the chain: an added number has at most eight.
  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned NUM_W      = 27;  // holds 99999999
  localparam int unsigned SUM_W      = 4;   // digit sum kept modulo ten

  localparam logic [31:0] ADD_MAX_VALUE = 32'd99999999;
  localparam logic [31:0] VERIFY_LIMIT  = 32'd1000000000;
  localparam logic [31:0] ERROR_RESULT  = 32'hFFFF_FFFF;

  // Reciprocal of ten: (x * RECIP10) >> RECIP_SHIFT is x / 10 for any 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_VERIFY = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // Word handed from cell to cell.
  typedef struct packed {
    cmd_t              cmd;
    logic              in_range;
    logic [NUM_W-1:0]  base;      // number whose check digit is computed
    logic [3:0]        last_dig;  // received check digit (verify and remove)
    logic [NUM_W-1:0]  rest;      // digits not yet consumed
    logic [SUM_W-1:0]  sum;       // running Luhn sum modulo ten
  } lane_t;

endpackage

### src/luhn_check_digit_unit.sv
// ----------------------------------------------------------------------------
// Luhn check digit unit
// Adds, verifies or removes a Luhn mod-10 check digit on a decimal number.
// ----------------------------------------------------------------------------
// Input channel: valid, stall, command, value. A word is taken at a rising
// edge with valid high and stall low. Output channel: res_valid, res_stall,
// result, ok; one output word for every input word, in order.
// The datapath is a front stage, a chain of eight digit cells (one decimal
// digit per cell, least significant first) and an output register. That is
// ten registers in a row, and every word passes through each of them. One word
// is accepted every cycle while the output is not stalled; the throughput is
// set by the single shared advance of the chain.
// When the receiver stalls a waiting output word, the whole chain holds and
// stall is raised towards the sender in the same cycle; it drops again as
// soon as the output word is taken. Reset empties the chain; there is no
// other state.
// ----------------------------------------------------------------------------
module luhn_check_digit_unit
  import luhn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  command,
  input  logic [31:0] value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [31:0] result,
  output logic        ok
);

  logic                en;
  logic [NUM_DIGITS:0] lane_valid;
  lane_t               lanes [NUM_DIGITS+1];

  assign en    = !(res_valid && res_stall);
  assign stall = !en;

  luhn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (valid),
    .command    (command),
    .value      (value),
    .lane_valid (lane_valid[0]),
    .lane       (lanes[0])
  );

  // Every second digit from the least significant one is doubled.
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    luhn_cell #(
      .DOUBLE ((k % 2) == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lane_valid[k]),
      .in_lane   (lanes[k]),
      .out_valid (lane_valid[k+1]),
      .out_lane  (lanes[k+1])
    );
  end

  luhn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .lane_valid (lane_valid[NUM_DIGITS]),
    .lane       (lanes[NUM_DIGITS]),
    .res_valid  (res_valid),
    .result     (result),
    .ok         (ok)
  );

endmodule

### src/luhn_front.sv
// ----------------------------------------------------------------------------
// Luhn front stage
// Range check, strip of the received check digit and set-up of the chain word.
// ----------------------------------------------------------------------------
module luhn_front
  import luhn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        valid,
  input  logic [1:0]  command,
  input  logic [31:0] value,
  output logic        lane_valid,
  output lane_t       lane
);

  logic [63:0] prod;
  logic [28:0] quot;
  logic [32:0] quot10;
  logic [31:0] low;
  cmd_t        cmd;
  lane_t       lane_next;

  assign cmd    = cmd_t'(command);
  assign prod   = {32'd0, value} * {32'd0, RECIP10};
  assign quot   = prod[63:RECIP_SHIFT];
  assign quot10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign low    = value - quot10[31:0];

  always_comb begin
    lane_next          = '0;
    lane_next.cmd      = cmd;
    lane_next.last_dig = low[3:0];
    case (cmd)
      CMD_ADD: begin
        lane_next.in_range = (value <= ADD_MAX_VALUE);
        lane_next.base     = value[NUM_W-1:0];
      end
      CMD_VERIFY, CMD_REMOVE: begin
        lane_next.in_range = (value < VERIFY_LIMIT);
        lane_next.base     = quot[NUM_W-1:0];
      end
      default: begin
        lane_next.in_range = 1'b0;
        lane_next.base     = quot[NUM_W-1:0];
      end
    endcase
    lane_next.rest = lane_next.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (en) begin
      lane_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane <= lane_next;
    end
  end

endmodule

### src/luhn_cell.sv
// ----------------------------------------------------------------------------
// Luhn digit cell
// Takes one decimal digit off the remaining number and adds it to the sum.
// ----------------------------------------------------------------------------
module luhn_cell
  import luhn_pkg::*;
#(
  parameter bit DOUBLE = 1'b1
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  lane_t in_lane,
  output logic  out_valid,
  output lane_t out_lane
);

  logic [NUM_W+31:0] prod;
  logic [23:0]       quot;
  logic [NUM_W:0]    quot10;
  logic [NUM_W-1:0]  low;
  logic [3:0]        dig;
  logic [4:0]        dbl;
  logic [3:0]        term;
  logic [4:0]        acc;
  lane_t             lane_next;

  assign prod   = {32'd0, in_lane.rest} * {{NUM_W{1'b0}}, RECIP10};
  assign quot   = prod[RECIP_SHIFT+23:RECIP_SHIFT];
  assign quot10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign low    = in_lane.rest - quot10[NUM_W-1:0];
  assign dig    = low[3:0];

  // A doubled digit above nine folds to its digit sum, which is 2d - 9.
  assign dbl  = {dig, 1'b0};
  assign term = DOUBLE ? ((dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0]) : dig;
  assign acc  = {1'b0, in_lane.sum} + {1'b0, term};

  always_comb begin
    lane_next      = in_lane;
    lane_next.rest = {{(NUM_W-24){1'b0}}, quot};
    lane_next.sum  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

### src/luhn_back.sv
// ----------------------------------------------------------------------------
// Luhn back stage
// Forms the check digit and the output word from the finished sum.
// ----------------------------------------------------------------------------
module luhn_back
  import luhn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        lane_valid,
  input  lane_t       lane,
  output logic        res_valid,
  output logic [31:0] result,
  output logic        ok
);

  logic [3:0]  check;
  logic [31:0] prot;
  logic        match;
  logic [31:0] result_next;
  logic        ok_next;

  // (9 * sum) mod 10 is the ten's complement of the sum.
  assign check = (lane.sum == 4'd0) ? 4'd0 : 4'(4'd10 - lane.sum);
  assign prot  = 32'({lane.base, 3'b000}) + 32'({lane.base, 1'b0}) + 32'(check);
  assign match = lane.in_range && (check == lane.last_dig);

  always_comb begin
    case (lane.cmd)
      CMD_ADD: begin
        ok_next     = lane.in_range;
        result_next = lane.in_range ? prot : ERROR_RESULT;
      end
      CMD_VERIFY: begin
        ok_next     = match;
        result_next = 32'd0;
      end
      CMD_REMOVE: begin
        ok_next     = match;
        result_next = match ? 32'(lane.base) : ERROR_RESULT;
      end
      default: begin
        ok_next     = 1'b0;
        result_next = ERROR_RESULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
      ok     <= ok_next;
    end
  end

endmodule
